>>> src/r2a_pkg.sv
// ----------------------------------------------------------------------------
// Radix-to-ASCII converter package
// Shared widths, character constants, FSM state type and the digit encoder.
// ----------------------------------------------------------------------------
package r2a_pkg;

   localparam int VALUE_FIELD_W       = 32;
   localparam int BASE_W              = 6;
   localparam int CHAR_W              = 7;
   localparam int DIGIT_W             = 6;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam logic [CHAR_W-1:0]  CH_ZERO            = 7'd48;
   localparam logic [CHAR_W-1:0]  CH_ALPHA_BASE      = 7'd87;
   localparam logic [CHAR_W-1:0]  CH_MINUS           = 7'd45;
   localparam logic [DIGIT_W-1:0] LAST_NUMERIC_DIGIT = 6'd9;
   localparam logic [BASE_W-1:0]  BASE_MIN           = 6'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX           = 6'd36;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_CHECK,
      ST_DIV,
      ST_POP_RD,
      ST_POP_WR
   } state_type;

   // Maps a digit value to its ASCII code: '0'-'9', then 'a'-'z'.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] wide_digit;
      wide_digit = {1'b0, digit};
      if (digit <= LAST_NUMERIC_DIGIT) begin
         return CH_ZERO + wide_digit;
      end else begin
         return CH_ALPHA_BASE + wide_digit;
      end
   endfunction

endpackage

>>> src/r2a_req_if.sv
// ----------------------------------------------------------------------------
// Radix-to-ASCII request channel
// Valid/ready channel carrying one number, its radix and the signed flag.
// ----------------------------------------------------------------------------
interface r2a_req_if;
   import r2a_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [VALUE_FIELD_W-1:0] value;
   logic [BASE_W-1:0]        base;
   logic                     signed_mode;

   modport source (output valid, output value, output base, output signed_mode,
                   input ready);
   modport sink   (input valid, input value, input base, input signed_mode,
                   output ready);

endinterface

>>> src/r2a_rsp_if.sv
// ----------------------------------------------------------------------------
// Radix-to-ASCII response channel
// Valid/ready channel carrying one ASCII character and its last flag.
// ----------------------------------------------------------------------------
interface r2a_rsp_if;
   import r2a_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);

endinterface

>>> src/radix_to_ascii_converter_top.sv
// ----------------------------------------------------------------------------
// Radix-to-ASCII converter
// Sequence: a number is accepted in idle and a minus sign is loaded if one leads;
// each digit then comes from a check state and the bit-serial divider, and each
// digit character is read from the stack and written out. A new number is taken
// only in idle, after the last character; an output stall holds the sign and pop.
// Reset is synchronous and active high; it returns the controller to idle and
// empties the output word register. The digit stack is not cleared.
// ----------------------------------------------------------------------------
module radix_to_ascii_converter_top #(
   parameter int VALUE_WIDTH = r2a_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   r2a_req_if.sink       req_if,
   r2a_rsp_if.source     rsp_if
);
   import r2a_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_W = $clog2(VALUE_WIDTH);

   // Controller state.
   state_type state_ff, state_in;

   // Working registers of the divider. The quotient register shifts left one
   // bit per cycle while quotient bits enter at the bottom, so after the last
   // step it holds the new quotient; the remainder is pushed and rem_ff cleared.
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [IDX_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // Output word register, which parts the stack from the response channel.
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   // Digit stack: a memory written at the push pointer and read, registered,
   // one below it.
   logic [DIGIT_W-1:0]     stack_mem [VALUE_WIDTH];
   logic [DIGIT_W-1:0]     rd_data_ff;

   // Control from the output decoder.
   logic                   accept;
   logic                   load_item;
   logic                   load_sign;
   logic                   div_step;
   logic                   push_en;
   logic [DIGIT_W-1:0]     push_data;
   logic                   pop_rd;
   logic                   emit;

   // Datapath terms.
   logic [VALUE_WIDTH-1:0] value_ext;
   logic                   item_negative;
   logic [VALUE_WIDTH-1:0] item_magnitude;
   logic [BASE_W-1:0]      base_sat;
   logic [DIGIT_W:0]       trial;
   logic                   trial_ge;
   logic [DIGIT_W:0]       trial_diff;
   logic [DIGIT_W-1:0]     rem_next;
   logic                   last_bit;
   logic                   quot_zero;
   logic                   count_full;
   logic                   count_zero;
   logic [CNT_W-1:0]       count_dec;
   logic                   out_free;

   // The value field is zero-extended or truncated to the working width.
   assign value_ext      = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, req_if.value});
   assign item_negative  = req_if.signed_mode & value_ext[VALUE_WIDTH-1];
   // Two's complement negation; the most negative value maps to itself, which
   // is exactly its magnitude read as unsigned.
   assign item_magnitude = item_negative ? (~value_ext + VALUE_WIDTH'(1)) : value_ext;

   // Bases outside 2 to 36 saturate to the nearest legal radix.
   always_comb begin
      if (req_if.base < BASE_MIN) begin
         base_sat = BASE_MIN;
      end else if (req_if.base > BASE_MAX) begin
         base_sat = BASE_MAX;
      end else begin
         base_sat = req_if.base;
      end
   end

   // One restoring division step: bring down the next dividend bit and
   // subtract the base when it fits. The remainder always stays below the base.
   assign trial      = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign trial_ge   = trial >= {1'b0, base_ff};
   assign trial_diff = trial - {1'b0, base_ff};
   assign rem_next   = trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
   assign last_bit   = bit_cnt_ff == IDX_W'(VALUE_WIDTH - 1);

   assign quot_zero  = quot_ff == '0;
   assign count_full = count_ff == CNT_W'(VALUE_WIDTH);
   assign count_zero = count_ff == '0;
   assign count_dec  = count_ff - CNT_W'(1);

   // The output word register can take a new character when it is empty or
   // its current word leaves in this cycle.
   assign out_free   = !out_valid_ff || rsp_if.ready;

   assign req_if.ready     = state_ff == ST_IDLE;
   assign accept           = req_if.valid && req_if.ready;
   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.char_code = out_char_ff;
   assign rsp_if.last      = out_last_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = item_negative ? ST_SIGN : ST_CHECK;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (quot_zero || count_full) ? ST_POP_RD : ST_DIV;
         end
         ST_DIV: begin
            if (last_bit) begin
               state_in = ST_CHECK;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_WR;
         end
         ST_POP_WR: begin
            if (out_free) begin
               state_in = count_zero ? ST_IDLE : ST_POP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decoder.
   always_comb begin
      load_item = 1'b0;
      load_sign = 1'b0;
      div_step  = 1'b0;
      push_en   = 1'b0;
      push_data = rem_next;
      pop_rd    = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            load_item = accept;
         end
         ST_SIGN: begin
            load_sign = out_free;
         end
         ST_CHECK: begin
            // A zero value still prints one '0' digit.
            if ((quot_zero || count_full) && count_zero) begin
               push_en   = 1'b1;
               push_data = '0;
            end
         end
         ST_DIV: begin
            div_step = 1'b1;
            push_en  = last_bit;
         end
         ST_POP_RD: begin
            pop_rd = 1'b1;
         end
         ST_POP_WR: begin
            emit = out_free;
         end
         default: begin
            load_item = 1'b0;
         end
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      bit_cnt_in   = bit_cnt_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (load_item) begin
         quot_in    = item_magnitude;
         rem_in     = '0;
         base_in    = base_sat;
         bit_cnt_in = '0;
         count_in   = '0;
      end

      if (div_step) begin
         quot_in    = {quot_ff[VALUE_WIDTH-2:0], trial_ge};
         rem_in     = last_bit ? '0 : rem_next;
         bit_cnt_in = last_bit ? '0 : bit_cnt_ff + IDX_W'(1);
      end

      if (push_en) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (pop_rd) begin
         count_in = count_dec;
      end

      if (load_sign) begin
         out_valid_in = 1'b1;
         out_char_in  = CH_MINUS;
         out_last_in  = 1'b0;
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = digit_char(rd_data_ff);
         out_last_in  = count_zero;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      base_ff     <= base_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Digit stack write and registered read.
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[count_ff[IDX_W-1:0]] <= push_data;
      end
      if (pop_rd) begin
         rd_data_ff <= stack_mem[count_dec[IDX_W-1:0]];
      end
   end

`ifndef SYNTHESIS
   // The stack pointer never runs past the stack.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VALUE_WIDTH))
      else $error("digit count beyond stack depth");

   // The partial remainder stays below the radix throughout a division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < {1'b0, base_ff}))
      else $error("partial remainder not below radix");

   // A pop is issued only while the stack holds digits.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_RD) |-> !count_zero)
      else $error("pop from empty digit stack");

   // An accepted word starts either the sign or the digit loop.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SIGN || state_ff == ST_CHECK))
      else $error("accepted word did not start conversion");

   // The final character is produced only once the stack is empty.
   assert property (@(posedge clock) disable iff (reset)
      (emit && count_zero) |=> (out_valid_ff && out_last_ff && state_ff == ST_IDLE))
      else $error("final character mismatch");
`endif

endmodule

>>> sim/r2a_char_checker.sv
// ----------------------------------------------------------------------------
// Radix-to-ASCII character checker
// Watches both channels of the converter. It predicts the character words of
// every accepted request word and compares each delivered character word,
// in order, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module r2a_char_checker #(
   parameter int VALUE_WIDTH = r2a_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [r2a_pkg::VALUE_FIELD_W-1:0] req_value,
   input  logic [r2a_pkg::BASE_W-1:0]        req_base,
   input  logic                              req_signed_mode,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [r2a_pkg::CHAR_W-1:0]        rsp_char_code,
   input  logic                              rsp_last,
   output int                                mismatch_count,
   output int                                pending_count,
   output int                                numbers_seen,
   output int                                minus_count,
   output int                                chars_checked
);
   import r2a_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } ascii_char_type;

   ascii_char_type expected_chars[$];
   int             mismatches;
   int             numbers;
   int             minuses;
   int             chars;

   function automatic logic [CHAR_W-1:0] ascii_of_digit(input int unsigned digit);
      if (digit <= LAST_NUMERIC_DIGIT) begin
         return CHAR_W'(CH_ZERO + digit);
      end else begin
         return CHAR_W'(CH_ALPHA_BASE + digit);
      end
   endfunction

   // Queues the characters of one number; returns 1 when a minus sign leads.
   function automatic bit push_expected_chars(input logic [VALUE_FIELD_W-1:0] value,
                                              input logic [BASE_W-1:0] base,
                                              input logic signed_mode);
      longint unsigned width_mask;
      longint unsigned quotient;
      int unsigned     radix;
      int unsigned     digits[$];
      ascii_char_type  ch;
      bit              negative;
      width_mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      quotient   = longint'(value) & width_mask;
      if (base < BASE_MIN) begin
         radix = BASE_MIN;
      end else if (base > BASE_MAX) begin
         radix = BASE_MAX;
      end else begin
         radix = base;
      end
      negative = signed_mode && (((quotient >> (VALUE_WIDTH - 1)) & 64'd1) != 0);
      if (negative) begin
         quotient     = (64'd0 - quotient) & width_mask;
         ch.char_code = CH_MINUS;
         ch.last      = 1'b0;
         expected_chars.push_back(ch);
      end
      // Remainders come out least significant first, so each goes to the front.
      do begin
         digits.push_front(int'(quotient % radix));
         quotient = quotient / radix;
      end while (quotient != 0);
      foreach (digits[i]) begin
         ch.char_code = ascii_of_digit(digits[i]);
         ch.last      = (i == digits.size() - 1);
         expected_chars.push_back(ch);
      end
      return negative;
   endfunction

   always @(posedge clock) begin
      ascii_char_type want;
      if (reset) begin
         expected_chars.delete();
         mismatches = 0;
         numbers    = 0;
         minuses    = 0;
         chars      = 0;
      end else begin
         // Characters are checked before this edge's request is predicted, since a
         // request can never answer on the edge that accepts it.
         if (rsp_valid && rsp_ready) begin
            chars++;
            if (expected_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("ERROR: character %0d '%c' (0x%02h) last=%0b arrived unexpected",
                           chars, rsp_char_code, rsp_char_code, rsp_last);
               end
            end else begin
               want = expected_chars.pop_front();
               if (want.char_code !== rsp_char_code || want.last !== rsp_last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("ERROR: char %0d want '%c' (%02h) last=%0b, got '%c' (%02h) last=%0b",
                              chars, want.char_code, want.char_code, want.last,
                              rsp_char_code, rsp_char_code, rsp_last);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            numbers++;
            if (push_expected_chars(req_value, req_base, req_signed_mode)) begin
               minuses++;
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_chars.size();
      numbers_seen   <= numbers;
      minus_count    <= minuses;
      chars_checked  <= chars;
   end

endmodule

>>> sim/radix_to_ascii_converter_top_test.sv
// ----------------------------------------------------------------------------
// Radix-to-ASCII converter testbench
// Drives numbers with radix and signed flag into the converter, first a
// directed set of corner cases and then random words, under bursty input and
// a patterned output stall. The character checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_to_ascii_converter_top_test;
   import r2a_pkg::*;

   // Number of random request words after the directed part.
   localparam int NUM_RANDOM     = 156;
   // The slowest correct run is roughly 180 words of up to 33 radix-2
   // characters each plus stalled character output; the limit is set well
   // above that.
   localparam int CYCLE_LIMIT    = 1_500_000;
   // The long output hold-off starts once this many words have been accepted
   // and lasts longer than the slowest single conversion.
   localparam int HOLDOFF_START  = 40;
   localparam int HOLDOFF_CYCLES = 1500;
   // Quiet time at the end, so that any stray character still shows up.
   localparam int TAIL_CYCLES    = 100;

   typedef enum int unsigned {
      PACE_FREE,
      PACE_COIN,
      PACE_SPARSE,
      PACE_PERIODIC
   } pace_mode_type;

   logic clock;
   logic reset;

   r2a_req_if req_ch ();
   r2a_rsp_if rsp_ch ();

   int          mismatch_count;
   int          pending_count;
   int          numbers_seen;
   int          minus_count;
   int          chars_checked;
   int unsigned burst_left;

   radix_to_ascii_converter_top #(
      .VALUE_WIDTH(DEFAULT_VALUE_WIDTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   r2a_char_checker #(
      .VALUE_WIDTH(DEFAULT_VALUE_WIDTH)
   ) char_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_value      (req_ch.value),
      .req_base       (req_ch.base),
      .req_signed_mode(req_ch.signed_mode),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_char_code  (rsp_ch.char_code),
      .rsp_last       (rsp_ch.last),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .numbers_seen   (numbers_seen),
      .minus_count    (minus_count),
      .chars_checked  (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Presents one request word at a falling edge and holds it until the
   // converter takes it. Words go out in bursts; when a burst runs out, valid
   // drops for a random gap and the payload carries noise meanwhile.
   task automatic offer_number(input logic [VALUE_FIELD_W-1:0] value,
                               input logic [BASE_W-1:0] base,
                               input logic signed_mode);
      req_ch.valid       <= 1'b1;
      req_ch.value       <= value;
      req_ch.base        <= base;
      req_ch.signed_mode <= signed_mode;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (burst_left == 0) begin
         req_ch.valid       <= 1'b0;
         req_ch.value       <= $urandom;
         req_ch.base        <= BASE_W'($urandom);
         req_ch.signed_mode <= 1'($urandom);
         repeat ($urandom_range(1, 12)) @(negedge clock);
         // Now and then a long burst, so that back-to-back words are seen too.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 5);
      end else begin
         burst_left--;
      end
   endtask

   // Output side: a pattern of its own, switching between free flow, coin
   // flips, sparse acceptance and a fixed period. Once, early in the run, it
   // holds off for a long stretch while the input side keeps offering words,
   // so that the converter stalls with a full character backlog.
   initial begin : rsp_pacing
      pace_mode_type mode;
      int unsigned   mode_left;
      int unsigned   period;
      int unsigned   tick;
      bit            holdoff_done;
      rsp_ch.ready = 1'b0;
      mode         = PACE_FREE;
      mode_left    = 0;
      period       = 2;
      tick         = 0;
      holdoff_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!holdoff_done && numbers_seen >= HOLDOFF_START) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            holdoff_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = pace_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
            period    = $urandom_range(2, 6);
         end
         mode_left--;
         tick++;
         case (mode)
            PACE_FREE: begin
               rsp_ch.ready <= 1'b1;
            end
            PACE_COIN: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            PACE_SPARSE: begin
               rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ch.ready <= (tick % period == 0);
            end
         endcase
      end
   end

   // Watchdog: a stuck handshake or a missing character ends the run here.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d characters still expected",
               cycle_count, pending_count);
      $display("FAIL radix_to_ascii_converter_top");
      $finish;
   end

   initial begin : stimulus
      logic [VALUE_FIELD_W-1:0] value;
      logic [BASE_W-1:0]        base;
      logic                     signed_mode;
      int unsigned              value_kind;

      // Every input is known from time zero; reset is held and then released at a falling edge.
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.value       = '0;
      req_ch.base        = BASE_MIN;
      req_ch.signed_mode = 1'b0;
      burst_left         = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words. Zero in both modes gives a lone '0'.
      offer_number(32'h0000_0000, 6'd10, 1'b0);
      offer_number(32'h0000_0000, 6'd2,  1'b1);
      // All ones: 32 binary digits unsigned, "-1" signed.
      offer_number(32'hFFFF_FFFF, 6'd2,  1'b0);
      offer_number(32'hFFFF_FFFF, 6'd10, 1'b1);
      offer_number(32'hFFFF_FFFF, 6'd16, 1'b1);
      offer_number(32'hFFFF_FFFF, 6'd36, 1'b0);
      // The most negative signed value prints its full magnitude after the
      // minus sign; in radix 2 this is the longest answer of all.
      offer_number(32'h8000_0000, 6'd2,  1'b1);
      offer_number(32'h8000_0000, 6'd10, 1'b1);
      offer_number(32'h8000_0000, 6'd16, 1'b0);
      offer_number(32'h8000_0001, 6'd36, 1'b1);
      offer_number(32'h7FFF_FFFF, 6'd36, 1'b1);
      // Radix fields below two act as two, above thirty-six as thirty-six.
      offer_number(32'd5,         6'd0,  1'b0);
      offer_number(32'd255,       6'd1,  1'b1);
      offer_number(32'd12345,     6'd37, 1'b0);
      offer_number(32'hDEAD_BEEF, 6'd63, 1'b1);
      // Digit boundaries: '9' to "10", 'a', 'z' and the carry from 'z' to "10".
      offer_number(32'd9,         6'd10, 1'b0);
      offer_number(32'd10,        6'd10, 1'b0);
      offer_number(32'd10,        6'd11, 1'b0);
      offer_number(32'd35,        6'd36, 1'b0);
      offer_number(32'd36,        6'd36, 1'b1);
      offer_number(32'd1,         6'd2,  1'b1);
      offer_number(32'd1,         6'd3,  1'b1);
      // Alternating bit patterns; unsigned mode never shows a minus sign.
      offer_number(32'hAAAA_AAAA, 6'd8,  1'b0);
      offer_number(32'h5555_5555, 6'd4,  1'b1);

      // Random words with a mix of value shapes.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         value_kind  = $urandom_range(0, 9);
         signed_mode = 1'($urandom_range(0, 1));
         case (value_kind)
            0, 1, 2, 3: value = $urandom;
            4, 5:       value = $urandom_range(0, 1000);
            6: begin
               value       = -VALUE_FIELD_W'($urandom_range(1, 1000));
               signed_mode = 1'b1;
            end
            7:          value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            8: begin
               case ($urandom_range(0, 3))
                  0:       value = 32'h0000_0000;
                  1:       value = 32'hFFFF_FFFF;
                  2:       value = 32'h8000_0000;
                  default: value = 32'h7FFF_FFFF;
               endcase
            end
            default:    value = $urandom | 32'h8000_0000;
         endcase
         // Mostly legal radices; now and then any field value, to reach the
         // saturation on both sides.
         if ($urandom_range(0, 6) == 0) begin
            base = BASE_W'($urandom_range(0, 63));
         end else begin
            base = BASE_W'($urandom_range(2, 36));
         end
         offer_number(value, base, signed_mode);
      end
      req_ch.valid <= 1'b0;

      // Drain: every word answers with at least one character, so the
      // backlog reaching zero means the converter is done.
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d with a leading minus) into %0d checked characters,",
               numbers_seen, minus_count, chars_checked);
      $display("with radix fields 0 to 63, bursty input and a %0d-cycle output hold-off.",
               HOLDOFF_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS radix_to_ascii_converter_top");
      end else begin
         $display("%0d mismatches, %0d characters never delivered",
                  mismatch_count, pending_count);
         $display("FAIL radix_to_ascii_converter_top");
      end
      $finish;
   end

endmodule
